@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every property is sampled on the
// rising edge of aclk and is ignored while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a trigger implies a consequence in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rrcc_pkg.sv @@
package rrcc_pkg;

    localparam int DefaultNumRegions = 8;
    // The entry index is three bits wide, so at most this many slots exist.
    localparam int MaxSlots          = 8;

    localparam int AddrW   = 64;
    localparam int LenW    = 32;
    localparam int IdxW    = 3;
    localparam int CountW  = 4;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 64;

    // Bits 63..47 of a canonical address are all zero or all one.
    localparam int TopShift = 47;
    localparam int TopW     = AddrW - TopShift;
    localparam logic [TopW-1:0] TopAllOne = 17'h1FFFF;

    // Slave tdata layout, from the lowest bit up.
    localparam int IdxLo   = 0;
    localparam int BaseLo  = IdxLo + IdxW;
    localparam int LimLo   = BaseLo + AddrW;
    localparam int RdBit   = LimLo + AddrW;
    localparam int WrBit   = RdBit + 1;
    localparam int AddrLo  = WrBit + 1;
    localparam int LenLo   = AddrLo + AddrW;
    localparam int NeedBit = LenLo + LenW;
    localparam int SDataW  = ((NeedBit + 1 + 7) / 8) * 8;
    localparam int MDataW  = 8;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_CHECK = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_REGIONS_IN_USE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STACK_LOW      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_STACK_HIGH     = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_NONCANON  = 3'd2,
        ST_WRAPS     = 3'd3,
        ST_UNCOVERED = 3'd4
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    write_table;
        logic    start_walk;
        logic    step;
        logic    load_out;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic    is_write_op;
        logic    zero_len;
        logic    pre_fail;
        status_t pre_status;
        logic    hit;
        logic    reach_end;
    } stat_t;

endpackage

@@ src/rrcc_ctrl.sv @@
module rrcc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  rrcc_pkg::stat_t stat,
    output rrcc_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRE,
        S_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.out_status  = rrcc_pkg::ST_OK;
        cmd.capture     = s_tvalid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (stat.is_write_op || stat.zero_len || stat.pre_fail) begin
                    // Finishes here once the output register can take the result.
                    if (out_free) begin
                        cmd.write_table = stat.is_write_op;
                        cmd.load_out    = 1'b1;
                        cmd.out_status  = (stat.is_write_op || stat.zero_len) ?
                                          rrcc_pkg::ST_OK : stat.pre_status;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.start_walk = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK: begin
                if (!stat.hit || stat.reach_end) begin
                    if (out_free) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = stat.hit ? rrcc_pkg::ST_OK :
                                                    rrcc_pkg::ST_UNCOVERED;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/rrcc_datapath.sv @@
module rrcc_datapath #(
    parameter int NUM_REGIONS = rrcc_pkg::DefaultNumRegions
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [rrcc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rrcc_pkg::CfgW-1:0]    cfg_wdata,
    input  logic [rrcc_pkg::SDataW-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  rrcc_pkg::cmd_t               cmd,
    output rrcc_pkg::stat_t              stat,
    output logic [rrcc_pkg::MDataW-1:0]  m_tdata
);

    // Only slots reachable by the three-bit entry index get storage.
    localparam int TableDepth = (NUM_REGIONS < rrcc_pkg::MaxSlots) ?
                                NUM_REGIONS : rrcc_pkg::MaxSlots;
    localparam int AW = rrcc_pkg::AddrW;

    logic [rrcc_pkg::CountW-1:0] regions_in_use_reg;
    logic [AW-1:0]               stack_low_reg;
    logic [AW-1:0]               stack_high_reg;

    logic [AW-1:0] start_reg [TableDepth];
    logic [AW-1:0] stop_reg  [TableDepth];
    logic          rd_ok_reg [TableDepth];
    logic          wr_ok_reg [TableDepth];

    logic                      op_reg;
    logic [rrcc_pkg::IdxW-1:0] idx_reg;
    logic [AW-1:0]             base_reg;
    logic [AW-1:0]             limit_reg;
    logic                      may_rd_reg;
    logic                      may_wr_reg;
    logic [AW-1:0]             addr_reg;
    logic [rrcc_pkg::LenW-1:0] len_reg;
    logic                      need_wr_reg;

    logic [AW-1:0] cur_reg;
    logic [AW-1:0] end_reg;
    logic [rrcc_pkg::MDataW-1:0] out_reg;

    logic [rrcc_pkg::TopW-1:0] top_bits;
    logic                      canonical;
    logic                      wraps;
    rrcc_pkg::status_t         pre_status;
    logic                      hit;
    logic [AW-1:0]             hit_stop;
    logic                      out_covered;
    logic                      out_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regions_in_use_reg <= '0;
            stack_low_reg      <= '0;
            stack_high_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rrcc_pkg::CFG_REGIONS_IN_USE:
                    regions_in_use_reg <= cfg_wdata[rrcc_pkg::CountW-1:0];
                rrcc_pkg::CFG_STACK_LOW:  stack_low_reg  <= cfg_wdata;
                rrcc_pkg::CFG_STACK_HIGH: stack_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= s_tuser;
            idx_reg     <= s_tdata[rrcc_pkg::IdxLo +: rrcc_pkg::IdxW];
            base_reg    <= s_tdata[rrcc_pkg::BaseLo +: AW];
            limit_reg   <= s_tdata[rrcc_pkg::LimLo +: AW];
            may_rd_reg  <= s_tdata[rrcc_pkg::RdBit];
            may_wr_reg  <= s_tdata[rrcc_pkg::WrBit];
            addr_reg    <= s_tdata[rrcc_pkg::AddrLo +: AW];
            len_reg     <= s_tdata[rrcc_pkg::LenLo +: rrcc_pkg::LenW];
            need_wr_reg <= s_tdata[rrcc_pkg::NeedBit];
        end
    end

    // Slots at or above the table depth are never written.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < TableDepth; i++) begin
            if (cmd.write_table && (idx_reg == rrcc_pkg::IdxW'(i))) begin
                start_reg[i] <= base_reg;
                stop_reg[i]  <= limit_reg;
                rd_ok_reg[i] <= may_rd_reg;
                wr_ok_reg[i] <= may_wr_reg;
            end
        end
    end

    assign top_bits  = addr_reg[AW-1:rrcc_pkg::TopShift];
    assign canonical = (top_bits == '0) || (top_bits == rrcc_pkg::TopAllOne);
    assign wraps     = {{(AW - rrcc_pkg::LenW){1'b0}}, len_reg} > ~addr_reg;

    always_comb begin
        if (addr_reg == '0) begin
            pre_status = rrcc_pkg::ST_NULL;
        end else if (!canonical) begin
            pre_status = rrcc_pkg::ST_NONCANON;
        end else if (wraps) begin
            pre_status = rrcc_pkg::ST_WRAPS;
        end else begin
            pre_status = rrcc_pkg::ST_OK;
        end
    end

    // Walk pointer and range end; the walk is done once a chosen region
    // ends at or beyond the end of the range.
    always_ff @(posedge aclk) begin
        if (cmd.start_walk) begin
            cur_reg <= addr_reg;
            end_reg <= addr_reg + {{(AW - rrcc_pkg::LenW){1'b0}}, len_reg};
        end else if (cmd.step) begin
            cur_reg <= hit_stop;
        end
    end

    // First usable table entry that holds the walk pointer, else the stack window.
    always_comb begin
        hit      = 1'b0;
        hit_stop = stack_high_reg;
        for (int i = 0; i < TableDepth; i++) begin
            if (!hit && (regions_in_use_reg > rrcc_pkg::CountW'(i)) &&
                (start_reg[i] < stop_reg[i]) &&
                (cur_reg >= start_reg[i]) && (cur_reg < stop_reg[i]) &&
                rd_ok_reg[i] && (!need_wr_reg || wr_ok_reg[i])) begin
                hit      = 1'b1;
                hit_stop = stop_reg[i];
            end
        end
        if (!hit && (stack_low_reg < stack_high_reg) &&
            (cur_reg >= stack_low_reg) && (cur_reg < stack_high_reg)) begin
            hit      = 1'b1;
            hit_stop = stack_high_reg;
        end
    end

    assign stat.is_write_op = (op_reg == rrcc_pkg::OP_WRITE);
    assign stat.zero_len    = (len_reg == '0);
    assign stat.pre_fail    = (pre_status != rrcc_pkg::ST_OK);
    assign stat.pre_status  = pre_status;
    assign stat.hit         = hit;
    assign stat.reach_end   = (hit_stop >= end_reg);

    assign out_covered = (cmd.out_status == rrcc_pkg::ST_OK);
    assign out_kind    = (op_reg == rrcc_pkg::OP_CHECK) && need_wr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {3'b000, out_kind, cmd.out_status, out_covered};
        end
    end

    assign m_tdata = out_reg;

endmodule

@@ src/region_range_coverage_check_core.sv @@
// Flow: an accepted item moves from IDLE to PRE; a write, zero-length or rejected check
// item loads its result into the output register from PRE, while any other check goes on
// to WALK, which steps region by region through table-wide compares until the range is
// covered or a gap is found. Only one item is in flight: s_tready is high only in IDLE,
// and a finished result also waits for m_tready to free the output register.
// Reset: synchronous active-low aresetn clears control and configuration, not the table.
`include "assert_macros.svh"

module region_range_coverage_check_core #(
    parameter int NUM_REGIONS = rrcc_pkg::DefaultNumRegions
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [rrcc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rrcc_pkg::CfgW-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // entry_index, entry_base, entry_limit, entry_may_read, entry_may_write,
    // check_address, check_length, need_write, zero padding
    input  logic [rrcc_pkg::SDataW-1:0]  s_tdata,
    // operation
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // covered, check_status, was_write_kind, zero padding
    output logic [rrcc_pkg::MDataW-1:0]  m_tdata
);

    rrcc_pkg::cmd_t  cmd;
    rrcc_pkg::stat_t stat;

    rrcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrcc_datapath #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

    `ASSERT_CLK(a_load_needs_slot, !cmd.load_out || !m_tvalid || m_tready, "result overwritten")
    `ASSERT_CLK(a_step_needs_hit, !cmd.step || stat.hit, "walk step without a hit")
    `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input accepted while busy")
    `ASSERT_NEXT(a_load_shows, cmd.load_out, m_tvalid, "loaded result not presented")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rrcc_pkg::*;

    localparam int NumRegions = DefaultNumRegions;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic             op;
        logic [IdxW-1:0]  idx;
        logic [AddrW-1:0] base;
        logic [AddrW-1:0] lim;
        logic             rd;
        logic             wr;
        logic [AddrW-1:0] addr;
        logic [LenW-1:0]  len;
        logic             need;
    } item_t;

    typedef struct packed {
        logic    cov;
        status_t st;
        logic    wk;
    } result_t;

    // One row of the directed table: either a register write or an item,
    // optionally with its result spelled out by hand.
    typedef struct packed {
        logic               is_cfg;
        logic [CfgIdxW-1:0] cfg_idx;
        logic [CfgW-1:0]    cfg_val;
        item_t              it;
        logic               typed;
        logic               exp_cov;
        status_t            exp_st;
    } row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgW-1:0]     cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [MDataW-1:0]   m_tdata;

    // Shadow copy of the region table and the configuration.
    logic [AddrW-1:0] tbl_base [MaxSlots];
    logic [AddrW-1:0] tbl_end  [MaxSlots];
    logic             tbl_rd   [MaxSlots];
    logic             tbl_wr   [MaxSlots];
    logic [CountW-1:0] used_count = '0;
    logic [AddrW-1:0]  stack_lo   = '0;
    logic [AddrW-1:0]  stack_hi   = '0;

    result_t pending_results[$];
    row_t    dir_tbl[$];
    int      errors    = 0;
    int      cycles    = 0;
    int      idle_pct  = 0;
    int      stall_pct = 0;
    logic [AddrW-1:0] chain_lo, chain_hi;

    region_range_coverage_check_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t chk(input logic [63:0] a, input logic [31:0] l, input logic n);
        item_t it;
        it = '0;
        it.op = OP_CHECK;
        it.addr = a;
        it.len = l;
        it.need = n;
        return it;
    endfunction

    function automatic item_t wrt(input logic [2:0] i, input logic [63:0] b,
                                  input logic [63:0] e, input logic r, input logic w);
        item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.idx = i;
        it.base = b;
        it.lim = e;
        it.rd = r;
        it.wr = w;
        return it;
    endfunction

    function automatic row_t row_item(input item_t it, input logic typed,
                                      input logic cov, input status_t st);
        row_t r;
        r = '0;
        r.it = it;
        r.typed = typed;
        r.exp_cov = cov;
        r.exp_st = st;
        return r;
    endfunction

    function automatic row_t row_cfg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // Walks the range region by region, always taking the first usable
    // table entry and falling back to the stack window.
    function automatic status_t walk_range(input logic [63:0] addr, input logic [31:0] len,
                                           input logic need);
        logic [63:0] cur, left, stop;
        logic        found;
        int          n, i, steps;
        if (len == '0) return ST_OK;
        if (addr == '0) return ST_NULL;
        if (addr[AddrW-1:TopShift] != '0 && addr[AddrW-1:TopShift] != TopAllOne)
            return ST_NONCANON;
        if ({32'd0, len} > ~addr) return ST_WRAPS;
        cur = addr;
        left = {32'd0, len};
        stop = '0;
        n = (int'(used_count) > NumRegions) ? NumRegions : int'(used_count);
        for (steps = 0; steps < NumRegions + 2; steps++) begin
            found = 1'b0;
            for (i = 0; i < n && !found; i++) begin
                if (tbl_base[i] < tbl_end[i] && cur >= tbl_base[i] && cur < tbl_end[i] &&
                    tbl_rd[i] && (!need || tbl_wr[i])) begin
                    found = 1'b1;
                    stop = tbl_end[i];
                end
            end
            if (!found && stack_lo < stack_hi && cur >= stack_lo && cur < stack_hi) begin
                found = 1'b1;
                stop = stack_hi;
            end
            if (!found) return ST_UNCOVERED;
            if (stop - cur >= left) return ST_OK;
            left = left - (stop - cur);
            cur = stop;
        end
        return ST_UNCOVERED;
    endfunction

    function automatic result_t predict_result(input item_t it);
        result_t r;
        if (it.op == OP_WRITE) begin
            if (int'(it.idx) < NumRegions) begin
                tbl_base[it.idx] = it.base;
                tbl_end[it.idx] = it.lim;
                tbl_rd[it.idx] = it.rd;
                tbl_wr[it.idx] = it.wr;
            end
            r.cov = 1'b1;
            r.st = ST_OK;
            r.wk = 1'b0;
        end else begin
            r.st = walk_range(it.addr, it.len, it.need);
            r.cov = (r.st == ST_OK);
            r.wk = it.need;
        end
        return r;
    endfunction

    task automatic send_item(input item_t it, input logic typed, input logic cov,
                             input status_t st);
        logic [SDataW-1:0] d;
        result_t           r;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        d = '0;
        d[IdxLo +: IdxW] = it.idx;
        d[BaseLo +: AddrW] = it.base;
        d[LimLo +: AddrW] = it.lim;
        d[RdBit] = it.rd;
        d[WrBit] = it.wr;
        d[AddrLo +: AddrW] = it.addr;
        d[LenLo +: LenW] = it.len;
        d[NeedBit] = it.need;
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_result(it);
        if (typed) begin
            r.cov = cov;
            r.st = st;
        end
        pending_results.push_back(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        drain_results();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_REGIONS_IN_USE: used_count = val[CountW-1:0];
            CFG_STACK_LOW:      stack_lo = val;
            CFG_STACK_HIGH:     stack_hi = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        logic [63:0] cur, start, stop, junk;
        logic [31:0] span;
        item_t       it;
        int          k, sel, j, tmp;
        int          perm [MaxSlots];
        idle_pct = idle;
        stall_pct = stall;

        // Lay out a chain of neighboring regions, with gaps, overlaps and
        // empty entries now and then, written into shuffled slots.
        junk = rand64();
        if ($urandom_range(1) == 1)
            cur = {TopAllOne, 1'b0, junk[45:0]};
        else
            cur = {17'd0, junk[46:0]} | 64'h1000;
        chain_lo = cur;
        for (k = 0; k < MaxSlots; k++) perm[k] = k;
        for (k = MaxSlots - 1; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        for (k = 0; k < MaxSlots; k++) begin
            if ($urandom_range(3) == 0)
                cur = cur + $urandom_range(1, 'h40);
            else if ($urandom_range(3) == 0 && cur - chain_lo > 'h20)
                cur = cur - $urandom_range(0, 'h20);
            start = cur;
            stop = cur + $urandom_range(1, 'h800);
            if ($urandom_range(15) == 0) stop = start;
            if (stop > cur) cur = stop;
            send_item(wrt(perm[k][2:0], start, stop, $urandom_range(9) != 0,
                          $urandom_range(3) != 0), 1'b0, 1'b0, ST_OK);
        end
        chain_hi = cur;
        span = 32'(chain_hi - chain_lo);

        junk = rand64();
        sel = $urandom_range(9);
        if (sel == 0)
            cfg_write(CFG_REGIONS_IN_USE, {junk[63:4], 4'd0});
        else if (sel == 1)
            cfg_write(CFG_REGIONS_IN_USE, {junk[63:4], 4'd15});
        else if (sel == 2)
            cfg_write(CFG_REGIONS_IN_USE, {junk[63:4], 4'($urandom_range(1, 7))});
        else
            cfg_write(CFG_REGIONS_IN_USE, {junk[63:4], 4'd8});
        case ($urandom_range(4))
            0: begin
                cfg_write(CFG_STACK_LOW, '0);
                cfg_write(CFG_STACK_HIGH, '0);
            end
            1: begin
                cfg_write(CFG_STACK_LOW, chain_hi - $urandom_range(0, 'h100));
                cfg_write(CFG_STACK_HIGH, chain_hi + $urandom_range(1, 'h800));
            end
            2: begin
                cfg_write(CFG_STACK_LOW, '0);
                cfg_write(CFG_STACK_HIGH, '1);
            end
            3: begin
                cfg_write(CFG_STACK_LOW, chain_hi);
                cfg_write(CFG_STACK_HIGH, chain_lo);
            end
            default: begin
                cfg_write(CFG_STACK_LOW, rand64());
                cfg_write(CFG_STACK_HIGH, rand64());
            end
        endcase

        for (k = 0; k < count; k++) begin
            // Unused fields carry random junk that the block must ignore.
            it.op = OP_CHECK;
            it.idx = 3'($urandom_range(7));
            it.base = rand64();
            it.lim = rand64();
            it.rd = 1'($urandom_range(1));
            it.wr = 1'($urandom_range(1));
            it.addr = rand64();
            it.len = $urandom;
            it.need = 1'($urandom_range(1));
            sel = $urandom_range(99);
            if (sel < 10) begin
                it.op = OP_WRITE;
                if ($urandom_range(3) != 0) begin
                    it.base = chain_lo + $urandom_range(0, span);
                    it.lim = it.base + $urandom_range(0, 'h800);
                    it.rd = $urandom_range(9) != 0;
                end
            end else if (sel < 80) begin
                it.addr = chain_lo + $urandom_range(0, span);
                it.len = $urandom_range(1, span + 'h20);
            end else if (sel < 85) begin
                // Fully random address and length.
            end else if (sel < 90) begin
                it.addr[AddrW-1:TopShift] = ($urandom_range(1) == 1) ? TopAllOne : '0;
            end else if (sel < 94) begin
                it.addr = '1 - $urandom_range(0, 'h100);
                if ($urandom_range(1) == 1) it.len = $urandom_range(1, 'h200);
            end else if (sel < 97) begin
                it.addr = '0;
            end else begin
                it.len = '0;
            end
            send_item(it, 1'b0, 1'b0, ST_OK);
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t got, want;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.cov = m_tdata[0];
            got.st = status_t'(m_tdata[3:1]);
            got.wk = m_tdata[4];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, m_tdata);
                errors = errors + 1;
            end else begin
                want = pending_results.pop_front();
                if (got.cov !== want.cov) begin
                    $display("%0t: covered expected %0d actual %0d", $time, want.cov, got.cov);
                    errors = errors + 1;
                end
                if (got.st !== want.st) begin
                    $display("%0t: check_status expected %0d actual %0d",
                             $time, want.st, got.st);
                    errors = errors + 1;
                end
                if (got.wk !== want.wk) begin
                    $display("%0t: was_write_kind expected %0d actual %0d",
                             $time, want.wk, got.wk);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        int k;
        // With no regions in use and the stack window off, every rejection
        // and the uncovered case can be read off directly.
        dir_tbl.push_back(row_item(chk('0, '0, 1'b0), 1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(chk('0, 32'd1, 1'b0), 1'b1, 1'b0, ST_NULL));
        dir_tbl.push_back(row_item(chk(64'h0000_8000_0000_0000, 32'd1, 1'b1),
                                   1'b1, 1'b0, ST_NONCANON));
        dir_tbl.push_back(row_item(chk(64'hFFFF_0000_0000_0000, 32'd1, 1'b0),
                                   1'b1, 1'b0, ST_NONCANON));
        dir_tbl.push_back(row_item(chk('1, 32'd2, 1'b1), 1'b1, 1'b0, ST_WRAPS));
        dir_tbl.push_back(row_item(chk(64'h1000, 32'd1, 1'b0), 1'b1, 1'b0, ST_UNCOVERED));
        dir_tbl.push_back(row_item(chk(64'hFFFF_8000_0000_0000, '1, 1'b1),
                                   1'b1, 1'b0, ST_UNCOVERED));
        // Fill every slot so that no check ever consults an unwritten entry.
        dir_tbl.push_back(row_item(wrt(3'd0, 64'h1000, 64'h2000, 1'b1, 1'b1),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd1, 64'h2000, 64'h3000, 1'b1, 1'b0),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd2, 64'h1800, 64'h4000, 1'b1, 1'b1),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd3, 64'h5000, 64'h5000, 1'b1, 1'b1),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd4, 64'h6000, 64'h7000, 1'b0, 1'b1),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd5, 64'hFFFF_FFFF_0000_0000, '1, 1'b1, 1'b0),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd6, 64'h4000, 64'h5000, 1'b1, 1'b1),
                                   1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_item(wrt(3'd7, '0, '1, 1'b1, 1'b1), 1'b1, 1'b1, ST_OK));
        dir_tbl.push_back(row_cfg(CFG_REGIONS_IN_USE, 64'd7));
        dir_tbl.push_back(row_cfg(CFG_STACK_LOW, 64'h8000));
        dir_tbl.push_back(row_cfg(CFG_STACK_HIGH, 64'h9000));
        dir_tbl.push_back(row_item(chk(64'h1000, 32'h3000, 1'b1), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h1000, 32'h4000, 1'b1), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h1000, 32'h4001, 1'b1), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h5000, 32'd1, 1'b0), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h6000, 32'd1, 1'b1), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h8000, 32'h1000, 1'b0), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h8000, 32'h1001, 1'b0), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'hFFFF_FFFF_0000_0000, '1, 1'b0),
                                   1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h7FFF_FFFF_FFFF, 32'd1, 1'b1), 1'b0, 1'b0, ST_OK));
        // A count above the table size, and a stack window spanning everything.
        dir_tbl.push_back(row_cfg(CFG_REGIONS_IN_USE, 64'd15));
        dir_tbl.push_back(row_cfg(CFG_STACK_LOW, '0));
        dir_tbl.push_back(row_cfg(CFG_STACK_HIGH, '1));
        dir_tbl.push_back(row_item(chk(64'h5000, 32'd1, 1'b0), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'h6000, '1, 1'b1), 1'b0, 1'b0, ST_OK));
        dir_tbl.push_back(row_item(chk(64'hFFFF_FFFF_FFFF_FFFE, 32'd1, 1'b1),
                                   1'b0, 1'b0, ST_OK));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < dir_tbl.size(); k++) begin
            if (dir_tbl[k].is_cfg)
                cfg_write(dir_tbl[k].cfg_idx, dir_tbl[k].cfg_val);
            else
                send_item(dir_tbl[k].it, dir_tbl[k].typed, dir_tbl[k].exp_cov,
                          dir_tbl[k].exp_st);
        end

        for (k = 0; k < 2; k++) begin
            run_phase(0, 0, 98);
            run_phase(71, 0, 98);
            run_phase(0, 71, 98);
            run_phase(10, 10, 98);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/rrcc_pkg.sv
src/rrcc_ctrl.sv
src/rrcc_datapath.sv
src/region_range_coverage_check_core.sv
sim/tb.sv
